// ===== hw/rtl/mexp_pkg.sv =====
// mexp_pkg: shared types and constants for the modular exponentiation block
// holds the modulus, the Barrett reciprocal and the multiplier request/response structs
// no dependencies

package mexp_pkg;

  // field widths
  localparam int unsigned VAL_W = 30;
  localparam int unsigned EXP_W = 31;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [EXP_W-1:0] exp_t;

  // prime modulus and the fixed exponent used for the inverse
  localparam val_t       MOD_P   = 30'd1000000007;
  localparam exp_t       INV_EXP = 31'd1000000005;

  // Barrett reciprocal floor(2^60 / p), fits in 31 bits
  localparam logic [63:0] BarrettMuFull = (64'd1 << 60) / 64'd1000000007;
  localparam logic [30:0] BARRETT_MU    = BarrettMuFull[30:0];

  // modulus and twice the modulus at remainder width
  localparam logic [31:0] MOD_X1 = 32'd1000000007;
  localparam logic [31:0] MOD_X2 = 32'd2000000014;

  // request to the shared modular multiplier
  typedef struct packed {
    logic start;
    val_t a;
    val_t b;
  } mm_req_t;

  // response from the shared modular multiplier
  typedef struct packed {
    logic done;
    val_t res;
  } mm_rsp_t;

endpackage

// ===== hw/rtl/mexp_chan_if.sv =====
// mexp_chan_if: valid/ready channel interfaces for requests and results
// depends on mexp_pkg for field types

interface mexp_in_if;
  import mexp_pkg::*;

  logic valid;
  logic ready;
  logic req_type;
  val_t base;
  exp_t exponent;

  modport source (output valid, output req_type, output base, output exponent, input ready);
  modport sink   (input valid, input req_type, input base, input exponent, output ready);
endinterface

interface mexp_out_if;
  import mexp_pkg::*;

  logic valid;
  logic ready;
  val_t power_result;

  modport source (output valid, output power_result, input ready);
  modport sink   (input valid, input power_result, output ready);
endinterface

// ===== hw/rtl/mexp_mulmod.sv =====
// mexp_mulmod: shared modular multiplier, a*b mod p with Barrett reduction
// one 31x31 multiplier reused in three of its four phases; depends on mexp_pkg

module mexp_mulmod (
  input  logic              clk,
  input  logic              rst_n,
  input  mexp_pkg::mm_req_t req,
  output mexp_pkg::mm_rsp_t rsp
);
  import mexp_pkg::*;

  // phase codes
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_MUL  = 3'd1;
  localparam logic [2:0] PH_QEST = 3'd2;
  localparam logic [2:0] PH_QM   = 3'd3;
  localparam logic [2:0] PH_FIX  = 3'd4;

  logic [2:0]  phase_r, phase_nxt;
  val_t        a_r, b_r;
  logic [59:0] p_r;
  logic [30:0] q3_r;
  logic [31:0] t_r;
  logic        done_r;
  val_t        res_r;

  logic [30:0] mul_x, mul_y;
  logic [61:0] mul_out;
  logic [31:0] r_raw, r_fix;

  // operand select for the one multiplier
  always_comb begin
    case (phase_r)
      PH_MUL: begin
        mul_x = {1'b0, a_r};
        mul_y = {1'b0, b_r};
      end
      PH_QEST: begin
        mul_x = p_r[59:29];
        mul_y = BARRETT_MU;
      end
      PH_QM: begin
        mul_x = q3_r;
        mul_y = {1'b0, MOD_P};
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign mul_out = mul_x * mul_y;

  // remainder below 3p, then one selected correction
  assign r_raw = p_r[31:0] - t_r;

  always_comb begin
    if (r_raw >= MOD_X2) begin
      r_fix = r_raw - MOD_X2;
    end else if (r_raw >= MOD_X1) begin
      r_fix = r_raw - MOD_X1;
    end else begin
      r_fix = r_raw;
    end
  end

  // phase sequencing
  always_comb begin
    case (phase_r)
      PH_IDLE: phase_nxt = req.start ? PH_MUL : PH_IDLE;
      PH_MUL:  phase_nxt = PH_QEST;
      PH_QEST: phase_nxt = PH_QM;
      PH_QM:   phase_nxt = PH_FIX;
      PH_FIX:  phase_nxt = PH_IDLE;
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= (phase_r == PH_FIX);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (phase_r == PH_IDLE && req.start) begin
      a_r <= req.a;
      b_r <= req.b;
    end
    if (phase_r == PH_MUL) begin
      p_r <= mul_out[59:0];
    end
    if (phase_r == PH_QEST) begin
      q3_r <= mul_out[61:31];
    end
    if (phase_r == PH_QM) begin
      t_r <= mul_out[31:0];
    end
    if (phase_r == PH_FIX) begin
      res_r <= r_fix[29:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

// ===== hw/rtl/modular_exponentiation.sv =====
// modular_exponentiation: base^exponent mod 1000000007 by square-and-multiply
// sequencer around mexp_mulmod; depends on mexp_pkg and mexp_chan_if
//
//   channel   | dir | payload                        | handshake
//   ----------+-----+--------------------------------+-----------
//   in_chan   | in  | req_type, base[29:0], exp[30:0]| valid/ready
//   out_chan  | out | power_result[29:0]             | valid/ready
//
// each modular multiply runs on the shared multiplier; an item takes 31 squarings plus one
// multiply by the base per one bit in the exponent (exponent forced to p-2 for an inverse)
// in_chan.ready is high only while the sequencer is idle
// the result sits in an output register, so a stalled out_chan does not stop the
// next transaction from being accepted; only a second finished result waits
// reset (rst_n low, synchronous) clears the sequencer and the output valid

module modular_exponentiation (
  input  logic          clk,
  input  logic          rst_n,
  mexp_in_if.sink       in_chan,
  mexp_out_if.source    out_chan
);
  import mexp_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SQR    = 3'd1;
  localparam logic [2:0] ST_SQR_W  = 3'd2;
  localparam logic [2:0] ST_MULB   = 3'd3;
  localparam logic [2:0] ST_MULB_W = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state_r, state_nxt;
  val_t       base_r, base_nxt;
  exp_t       exp_r, exp_nxt;
  val_t       acc_r, acc_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  val_t       out_res_r, out_res_nxt;

  mm_req_t    mm_req;
  mm_rsp_t    mm_rsp;
  logic       in_fire;
  logic       out_load;
  val_t       base_red;

  mexp_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_load      = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);

  // reduce an out-of-range base once
  assign base_red = (in_chan.base >= MOD_P) ? (in_chan.base - MOD_P) : in_chan.base;

  // multiplier requests
  always_comb begin
    mm_req.start = (state_r == ST_SQR) || (state_r == ST_MULB);
    mm_req.a     = acc_r;
    mm_req.b     = (state_r == ST_MULB) ? base_r : acc_r;
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    base_nxt  = base_r;
    exp_nxt   = exp_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          base_nxt  = base_red;
          exp_nxt   = in_chan.req_type ? INV_EXP : in_chan.exponent;
          acc_nxt   = 30'd1;
          cnt_nxt   = 5'(EXP_W - 1);
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        state_nxt = ST_SQR_W;
      end
      ST_SQR_W: begin
        if (mm_rsp.done) begin
          acc_nxt = mm_rsp.res;
          if (exp_r[EXP_W-1]) begin
            state_nxt = ST_MULB;
          end else if (cnt_r == 5'd0) begin
            state_nxt = ST_DONE;
          end else begin
            cnt_nxt   = cnt_r - 5'd1;
            exp_nxt   = {exp_r[EXP_W-2:0], 1'b0};
            state_nxt = ST_SQR;
          end
        end
      end
      ST_MULB: begin
        state_nxt = ST_MULB_W;
      end
      ST_MULB_W: begin
        if (mm_rsp.done) begin
          acc_nxt = mm_rsp.res;
          if (cnt_r == 5'd0) begin
            state_nxt = ST_DONE;
          end else begin
            cnt_nxt   = cnt_r - 5'd1;
            exp_nxt   = {exp_r[EXP_W-2:0], 1'b0};
            state_nxt = ST_SQR;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_res_nxt   = acc_r;
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    base_r    <= base_nxt;
    exp_r     <= exp_nxt;
    acc_r     <= acc_nxt;
    cnt_r     <= cnt_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.power_result = out_res_r;

endmodule

// ===== hw/rtl/mexp_checker.sv =====
// mexp_checker: port-level assertions for modular_exponentiation
// bound to the top level below; depends on mexp_pkg

module mexp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input mexp_pkg::val_t     out_power_result
);
  import mexp_pkg::*;

  // one transaction at a time: ready drops right after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready stayed high after an accepted transaction");

  // every result is fully reduced
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_power_result < MOD_P))
    else $error("power_result not below the modulus");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_power_result)))
    else $error("result dropped or changed while stalled");

  // reset leaves the block idle with no result pending
  assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("block not idle after reset");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_power_result (out_chan.power_result)
);

// ===== tb/modular_exponentiation_test.sv =====
// modular_exponentiation_test: self-checking bench for base^exponent mod 1000000007
// random and directed power/inverse requests checked against an in-bench square-and-multiply
// depends on mexp_pkg, mexp_chan_if and modular_exponentiation

module modular_exponentiation_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mexp_pkg::*;

  // request kinds on req_type
  localparam bit REQ_POWER   = 1'b0;
  localparam bit REQ_INVERSE = 1'b1;

  localparam int RANDOM_ITEMS     = 1500;
  localparam int QUIET_TAIL       = 150;
  localparam int LONG_HOLD_CYCLES = 2000;
  localparam int DRAIN_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT   = 12000;
  localparam int MAX_REPORTS      = 10;

  localparam val_t BASE_MAX = '1;
  localparam exp_t EXP_MAX  = '1;

  typedef struct {
    bit   kind;
    val_t base;
    exp_t exponent;
  } exp_req_t;

  typedef struct {
    exp_req_t req;
    val_t     power;
  } power_expect_t;

  bit   clk = 1'b0;
  logic rst_n = 1'b0;

  mexp_in_if  in_if ();
  mexp_out_if out_if ();

  modular_exponentiation u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  exp_req_t      request_queue[$];
  power_expect_t expected_powers[$];
  power_expect_t oldest_power;
  exp_req_t      taken_req;
  exp_req_t      next_req;

  int item_total;
  int issued_total;
  int accepted_total;
  int received_total;
  int mismatch_count;
  int idle_cycles;
  int src_gap;
  int sink_gap;
  bit in_accepted;
  bit out_accepted;
  bit long_hold;

  // square-and-multiply from the top exponent bit down
  function automatic val_t predict_power(bit kind, val_t base, exp_t exponent);
    longint unsigned p;
    longint unsigned b;
    longint unsigned acc;
    exp_t            e;
    p = longint'(MOD_P);
    b = longint'(base);
    if (b >= p) begin
      b = b - p;
    end
    e = (kind == REQ_INVERSE) ? INV_EXP : exponent;
    acc = 1;
    for (int i = EXP_W - 1; i >= 0; i--) begin
      acc = (acc * acc) % p;
      if (e[i]) begin
        acc = (acc * b) % p;
      end
    end
    return val_t'(acc);
  endfunction

  function automatic void add_request(bit kind, val_t base, exp_t exponent);
    exp_req_t r;
    r.kind     = kind;
    r.base     = base;
    r.exponent = exponent;
    request_queue.push_back(r);
  endfunction

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // stimulus, reset and end of run
  initial begin
    exp_req_t r;
    int       pick;
    in_if.valid    = 1'b0;
    in_if.req_type = REQ_POWER;
    in_if.base     = '0;
    in_if.exponent = '0;
    out_if.ready   = 1'b0;

    // directed: zero exponent, zero base, field extremes, unreduced bases, inverses
    add_request(REQ_POWER, 30'd0, 31'd0);
    add_request(REQ_POWER, 30'd5, 31'd0);
    add_request(REQ_POWER, 30'd0, 31'd1);
    add_request(REQ_POWER, 30'd0, EXP_MAX);
    add_request(REQ_POWER, 30'd1, EXP_MAX);
    add_request(REQ_POWER, MOD_P - 30'd1, EXP_MAX);
    add_request(REQ_POWER, BASE_MAX, EXP_MAX);
    add_request(REQ_POWER, MOD_P, 31'd3);
    add_request(REQ_POWER, MOD_P + 30'd1, 31'd12345);
    add_request(REQ_POWER, 30'd2, 31'd30);
    add_request(REQ_POWER, 30'd2, 31'h4000_0000);
    add_request(REQ_POWER, 30'd123456789, 31'd1);
    add_request(REQ_POWER, 30'd987654321, 31'd2);
    add_request(REQ_POWER, 30'h2AAA_AAAA, 31'h5555_5555);
    add_request(REQ_POWER, 30'h1555_5555, 31'h2AAA_AAAA);
    add_request(REQ_INVERSE, 30'd0, 31'd77);
    add_request(REQ_INVERSE, 30'd1, 31'd0);
    add_request(REQ_INVERSE, MOD_P - 30'd1, EXP_MAX);
    add_request(REQ_INVERSE, 30'd2, 31'd0);
    add_request(REQ_INVERSE, MOD_P, 31'd5);
    add_request(REQ_INVERSE, BASE_MAX, 31'd9);
    add_request(REQ_INVERSE, 30'd3, EXP_MAX);

    // random: full-range fields with extremes and short exponents mixed in
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r.kind = ($urandom_range(0, 3) == 0) ? REQ_INVERSE : REQ_POWER;
      pick = $urandom_range(0, 19);
      if (pick < 17) begin
        r.base = val_t'($urandom);
      end else if (pick == 17) begin
        r.base = ($urandom_range(0, 1) == 0) ? 30'd0 : 30'd1;
      end else if (pick == 18) begin
        r.base = MOD_P - val_t'($urandom_range(0, 1));
      end else begin
        r.base = BASE_MAX - val_t'($urandom_range(0, 3));
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        r.exponent = exp_t'($urandom);
      end else if (pick < 8) begin
        r.exponent = exp_t'($urandom_range(0, 64));
      end else if (pick == 8) begin
        r.exponent = exp_t'(1) << $urandom_range(0, EXP_W - 1);
      end else begin
        r.exponent = ($urandom_range(0, 1) == 0) ? EXP_MAX : '0;
      end
      request_queue.push_back(r);
    end
    item_total = request_queue.size();

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_total < item_total || expected_powers.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // request driver: offers the next pending item, with random idle bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_accepted) begin
      if (src_gap > 0) begin
        src_gap--;
        in_if.valid <= 1'b0;
      end else if (request_queue.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (!((issued_total % 300) >= 240 || request_queue.size() < QUIET_TAIL) &&
                   $urandom_range(0, 5) == 0) begin
        src_gap = $urandom_range(0, 5);
        in_if.valid <= 1'b0;
      end else begin
        next_req = request_queue.pop_front();
        issued_total++;
        in_if.valid    <= 1'b1;
        in_if.req_type <= next_req.kind;
        in_if.base     <= next_req.base;
        in_if.exponent <= next_req.exponent;
      end
    end
  end

  // result receiver: random stall bursts, plus the long hold-off
  always @(negedge clk) begin
    if (!rst_n || long_hold) begin
      out_if.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_if.ready <= 1'b0;
    end else if (!((received_total % 300) >= 240 || received_total + QUIET_TAIL > item_total) &&
                 $urandom_range(0, 5) == 0) begin
      sink_gap = $urandom_range(0, 5);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // long receiver hold-off so the block fills up and backs up its input
  initial begin
    long_hold = 1'b0;
    wait (received_total >= 100);
    @(posedge clk);
    long_hold = 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    long_hold = 1'b0;
  end

  // monitor: predict on each request transaction, check each result transaction
  always @(posedge clk) begin
    in_accepted  = 1'b0;
    out_accepted = 1'b0;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        in_accepted        = 1'b1;
        taken_req.kind     = in_if.req_type;
        taken_req.base     = in_if.base;
        taken_req.exponent = in_if.exponent;
        expected_powers.push_back('{taken_req,
            predict_power(taken_req.kind, taken_req.base, taken_req.exponent)});
        accepted_total++;
      end
      if (out_if.valid && out_if.ready) begin
        out_accepted = 1'b1;
        received_total++;
        if (expected_powers.size() == 0) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("unexpected result transaction: power_result=%0d", out_if.power_result);
          end
          mismatch_count++;
        end else begin
          oldest_power = expected_powers.pop_front();
          if (out_if.power_result !== oldest_power.power) begin
            if (mismatch_count < MAX_REPORTS) begin
              $display("power_result mismatch: kind=%0d base=%0d exponent=%0d expected %0d got %0d",
                       oldest_power.req.kind, oldest_power.req.base,
                       oldest_power.req.exponent, oldest_power.power, out_if.power_result);
            end
            mismatch_count++;
          end
        end
      end

      // watchdog on cycles with no transaction on either side
      if (in_accepted || out_accepted) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule

// ===== files.f =====
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_chan_if.sv
hw/rtl/mexp_mulmod.sv
hw/rtl/modular_exponentiation.sv
hw/rtl/mexp_checker.sv
tb/modular_exponentiation_test.sv
